/* hdl/pfpw_pkg.sv */
`default_nettype none

package pfpw_pkg;

   // default geometry
   localparam int DEF_PAGE_BYTES  = 64;
   localparam int DEF_FLASH_BYTES = 32768;

   // operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_BUFFERED   = 3'd0;
   localparam logic [2:0] STATUS_READ_OK    = 3'd1;
   localparam logic [2:0] STATUS_READ_DENY  = 3'd2;
   localparam logic [2:0] STATUS_PROGRAMMED = 3'd3;
   localparam logic [2:0] STATUS_UNCHANGED  = 3'd4;
   localparam logic [2:0] STATUS_WRITE_DENY = 3'd5;

   // configuration register indexes
   localparam logic [2:0] REG_CONFIG_START = 3'd0;
   localparam logic [2:0] REG_CONFIG_END   = 3'd1;
   localparam logic [2:0] REG_META_START   = 3'd2;
   localparam logic [2:0] REG_META_END     = 3'd3;
   localparam logic [2:0] REG_BOOT_START   = 3'd4;
   localparam logic [2:0] REG_FLASH_LIMIT  = 3'd5;

endpackage

`default_nettype wire

/* hdl/protected_flash_page_writer_core.sv */
// read, or a write byte inside an open segment: result 2 cycles after accept,
// next item accepted in the cycle the result shows (2 cycles per item)
// first byte of a segment: 3 more cycles for the page/offset split
// closing a changed, allowed segment of n bytes: n+1 more cycles to copy the buffer
// reset: a clearing pass of FLASH_BYTES cycles erases the store to 0xFF, busy stays
// high meanwhile; results are strobes the receiver cannot stall
`default_nettype none

module protected_flash_page_writer_core
   import pfpw_pkg::*;
#(
   parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
   parameter int FLASH_BYTES = DEF_FLASH_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_last,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_data,
   output logic [2:0]       rsp_status,
   output logic [8:0]       rsp_page_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int AW = $clog2(FLASH_BYTES);
   localparam int OW = $clog2(PAGE_BYTES);
   localparam logic [16:0] FLASH_END = 17'(FLASH_BYTES);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SPLIT  = 3'd2;
   localparam logic [2:0] ST_ACCESS = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   // window test: first..last lies wholly in [lo, hi)
   function automatic logic in_window(input logic [15:0] lo, input logic [16:0] hi,
                                      input logic [15:0] first, input logic [15:0] lastb);
      in_window = (first <= lastb) && (lo <= first) && ({1'b0, lastb} < hi);
   endfunction

   // memories
   logic [7:0] store_mem [FLASH_BYTES];
   logic [7:0] page_buf  [PAGE_BYTES];

   logic          store_rd_en, store_wr_en;
   logic [AW-1:0] store_rd_addr, store_wr_addr;
   logic [7:0]    store_wr_data, store_q;
   logic          buf_wr_en, buf_rd_en;
   logic [OW-1:0] buf_wr_off;
   logic [7:0]    buf_q;

   // control and request registers
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          op_ff, op_in;
   logic          last_ff, last_in;
   logic [7:0]    data_ff, data_in;
   logic [15:0]   cur_ff, cur_in;
   logic          oor_ff, oor_in;

   // segment state
   logic [15:0]   seg_start_ff, seg_start_in;
   logic [15:0]   next_addr_ff, next_addr_in;
   logic          seg_open_ff, seg_open_in;
   logic          seg_changed_ff, seg_changed_in;
   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] soff_ff, soff_in;
   logic [8:0]    page_ff, page_in;

   // commit sweep
   logic [OW-1:0] rd_off_ff, rd_off_in;
   logic [15:0]   rd_addr_ff, rd_addr_in;
   logic          issued_ff, issued_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_last_ff, pend_last_in;
   logic [15:0]   pend_addr_ff, pend_addr_in;

   // configuration
   logic [15:0] cfg_start_ff, meta_start_ff, boot_start_ff;
   logic [16:0] cfg_end_ff, meta_end_ff, flash_limit_ff;

   // result
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [8:0] rsp_page_ff, rsp_page_in;

   // page split unit
   logic          split_start;
   logic          split_valid;
   logic [8:0]    split_page;
   logic [OW-1:0] split_offset;

   logic accept;
   logic [7:0]  store_val;
   logic        diff, changed_now, close_seg, allowed, read_ok;
   logic [15:0] next_cur;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   pfpw_page_split #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (split_start),
      .in_address (req_address),
      .out_valid  (split_valid),
      .out_page   (split_page),
      .out_offset (split_offset)
   );

   // flash store: one read and one write port
   always_ff @(posedge clock) begin
      if (store_wr_en) begin
         store_mem[store_wr_addr] <= store_wr_data;
      end
      if (store_rd_en) begin
         store_q <= store_mem[store_rd_addr];
      end
   end

   // page buffer: written by merged bytes, read by the commit sweep
   always_ff @(posedge clock) begin
      if (buf_wr_en) begin
         page_buf[buf_wr_off] <= data_ff;
      end
      if (buf_rd_en) begin
         buf_q <= page_buf[rd_off_ff];
      end
   end

   // byte checks on the registered store data
   always_comb begin
      store_val   = oor_ff ? 8'hFF : store_q;
      diff        = (store_val != data_ff);
      changed_now = seg_changed_ff || diff;
      next_cur    = cur_ff + 16'd1;
      close_seg   = last_ff || (cur_ff == 16'hFFFF) || (off_ff == OW'(PAGE_BYTES - 1));
      allowed     = (in_window(cfg_start_ff, cfg_end_ff, seg_start_ff, cur_ff) ||
                     in_window(boot_start_ff, flash_limit_ff, seg_start_ff, cur_ff)) &&
                    ({1'b0, cur_ff} < FLASH_END);
      read_ok     = in_window(cfg_start_ff, cfg_end_ff, cur_ff, cur_ff) ||
                    in_window(meta_start_ff, meta_end_ff, cur_ff, cur_ff);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      data_in        = data_ff;
      cur_in         = cur_ff;
      oor_in         = oor_ff;
      seg_start_in   = seg_start_ff;
      next_addr_in   = next_addr_ff;
      seg_open_in    = seg_open_ff;
      seg_changed_in = seg_changed_ff;
      off_in         = off_ff;
      soff_in        = soff_ff;
      page_in        = page_ff;
      rd_off_in      = rd_off_ff;
      rd_addr_in     = rd_addr_ff;
      issued_in      = issued_ff;
      pend_valid_in  = 1'b0;
      pend_last_in   = pend_last_ff;
      pend_addr_in   = pend_addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_page_in    = rsp_page_ff;
      store_rd_en    = 1'b0;
      store_rd_addr  = cur_ff[AW-1:0];
      store_wr_en    = 1'b0;
      store_wr_addr  = pend_addr_ff[AW-1:0];
      store_wr_data  = buf_q;
      buf_wr_en      = 1'b0;
      buf_wr_off     = off_ff;
      buf_rd_en      = 1'b0;
      split_start    = 1'b0;

      unique case (state_ff)
         // erase sweep after reset
         ST_CLEAR: begin
            store_wr_en   = 1'b1;
            store_wr_addr = clr_ff;
            store_wr_data = 8'hFF;
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == AW'(FLASH_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // request transfer
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               last_in = req_last;
               data_in = req_data;
               if (req_operation == OP_WRITE && seg_open_ff) begin
                  cur_in = next_addr_ff;
               end else begin
                  cur_in = req_address;
               end
               oor_in = ({1'b0, cur_in} >= FLASH_END);
               if (req_operation == OP_WRITE && !seg_open_ff) begin
                  // first byte of a segment: find its page and offset
                  seg_start_in = req_address;
                  split_start  = 1'b1;
                  state_in     = ST_SPLIT;
               end else begin
                  store_rd_en   = 1'b1;
                  store_rd_addr = cur_in[AW-1:0];
                  state_in      = ST_ACCESS;
               end
            end
         end

         // wait for the split, then fetch the stored byte
         ST_SPLIT: begin
            if (split_valid) begin
               off_in      = split_offset;
               soff_in     = split_offset;
               page_in     = split_page;
               store_rd_en = 1'b1;
               state_in    = ST_ACCESS;
            end
         end

         // store data is here: answer a read or merge a write byte
         ST_ACCESS: begin
            state_in = ST_IDLE;
            if (op_ff == OP_READ) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = 9'd0;
               if (read_ok) begin
                  rsp_data_in   = store_val;
                  rsp_status_in = STATUS_READ_OK;
               end else begin
                  rsp_data_in   = 8'd0;
                  rsp_status_in = STATUS_READ_DENY;
               end
            end else begin
               buf_wr_en    = 1'b1;
               next_addr_in = next_cur;
               rsp_data_in  = 8'd0;
               if (!close_seg) begin
                  seg_open_in    = 1'b1;
                  seg_changed_in = changed_now;
                  off_in         = off_ff + OW'(1);
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = STATUS_BUFFERED;
                  rsp_page_in    = 9'd0;
               end else begin
                  seg_open_in    = 1'b0;
                  seg_changed_in = 1'b0;
                  if (!allowed) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_WRITE_DENY;
                     rsp_page_in   = 9'd0;
                  end else if (changed_now) begin
                     rd_off_in  = soff_ff;
                     rd_addr_in = seg_start_ff;
                     issued_in  = 1'b0;
                     state_in   = ST_COMMIT;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_UNCHANGED;
                     rsp_page_in   = page_ff;
                  end
               end
            end
         end

         // copy the segment bytes from the buffer into the store
         ST_COMMIT: begin
            if (!issued_ff) begin
               buf_rd_en     = 1'b1;
               rd_off_in     = rd_off_ff + OW'(1);
               rd_addr_in    = rd_addr_ff + 16'd1;
               pend_valid_in = 1'b1;
               pend_addr_in  = rd_addr_ff;
               pend_last_in  = (rd_addr_ff == cur_ff);
               issued_in     = (rd_addr_ff == cur_ff);
            end
            if (pend_valid_ff) begin
               store_wr_en = 1'b1;
               if (pend_last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 8'd0;
                  rsp_status_in = STATUS_PROGRAMMED;
                  rsp_page_in   = page_ff;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         seg_start_ff   <= 16'd0;
         next_addr_ff   <= 16'd0;
         seg_open_ff    <= 1'b0;
         seg_changed_ff <= 1'b0;
         issued_ff      <= 1'b1;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         seg_start_ff   <= seg_start_in;
         next_addr_ff   <= next_addr_in;
         seg_open_ff    <= seg_open_in;
         seg_changed_ff <= seg_changed_in;
         issued_ff      <= issued_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      data_ff       <= data_in;
      cur_ff        <= cur_in;
      oor_ff        <= oor_in;
      off_ff        <= off_in;
      soff_ff       <= soff_in;
      page_ff       <= page_in;
      rd_off_ff     <= rd_off_in;
      rd_addr_ff    <= rd_addr_in;
      pend_last_ff  <= pend_last_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   // configuration register transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_ff   <= 16'd0;
         cfg_end_ff     <= 17'd0;
         meta_start_ff  <= 16'd0;
         meta_end_ff    <= 17'd0;
         boot_start_ff  <= 16'd0;
         flash_limit_ff <= FLASH_END;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CONFIG_START: cfg_start_ff   <= csr_data[15:0];
            REG_CONFIG_END:   cfg_end_ff     <= csr_data;
            REG_META_START:   meta_start_ff  <= csr_data[15:0];
            REG_META_END:     meta_end_ff    <= csr_data;
            REG_BOOT_START:   boot_start_ff  <= csr_data[15:0];
            REG_FLASH_LIMIT:  flash_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_index = rsp_page_ff;

endmodule

`default_nettype wire

/* hdl/pfpw_page_split.sv */
`default_nettype none

// splits a byte address into page number and offset within the page,
// three register stages: reciprocal multiply, back-multiply, one correction
module pfpw_page_split
   import pfpw_pkg::*;
#(
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [15:0]                   in_address,
   output logic                               out_valid,
   output logic [8:0]                         out_page,
   output logic [$clog2(PAGE_BYTES)-1:0]      out_offset
);

   localparam int OW        = $clog2(PAGE_BYTES);
   localparam int DIV_SHIFT = 24;
   localparam int DIV_MULT  = (1 << DIV_SHIFT) / PAGE_BYTES;

   logic        v1_ff, v2_ff, v3_ff;
   logic [39:0] prod_ff, prod_in;
   logic [15:0] addr1_ff, addr2_ff;
   logic [15:0] quot0, quot0_ff;
   logic [24:0] back_ff, back_in;
   logic [16:0] rem0;
   logic [8:0]  page_in, page_ff;
   logic [OW-1:0] offset_in, offset_ff;

   // stage 1: multiply by the scaled reciprocal
   assign prod_in = 40'(in_address) * 40'(DIV_MULT);

   // stage 2: quotient estimate, at most one below the true quotient
   assign quot0   = prod_ff[DIV_SHIFT +: 16];
   assign back_in = 25'(quot0) * 25'(PAGE_BYTES);

   // stage 3: remainder and single correction step
   always_comb begin
      rem0 = {1'b0, addr2_ff} - back_ff[16:0];
      if (rem0 >= 17'(PAGE_BYTES)) begin
         offset_in = OW'(rem0 - 17'(PAGE_BYTES));
         page_in   = quot0_ff[8:0] + 9'd1;
      end else begin
         offset_in = OW'(rem0);
         page_in   = quot0_ff[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      prod_ff   <= prod_in;
      addr1_ff  <= in_address;
      quot0_ff  <= quot0;
      back_ff   <= back_in;
      addr2_ff  <= addr1_ff;
      page_ff   <= page_in;
      offset_ff <= offset_in;
   end

   assign out_valid  = v3_ff;
   assign out_page   = page_ff;
   assign out_offset = offset_ff;

endmodule

`default_nettype wire

/* bench/pfpw_checker.sv */
`timescale 1ns / 100ps

module pfpw_checker
   import pfpw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_read_data,
   input  logic [2:0]  rsp_status,
   input  logic [8:0]  rsp_page_index,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          pages_programmed
);

   localparam int PAGE  = DEF_PAGE_BYTES;
   localparam int STORE = DEF_FLASH_BYTES;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] status;
      logic [8:0] page_index;
   } access_outcome_type;

   // shadow of the flash contents and the open segment
   logic [7:0]  store_mem [STORE];
   logic [7:0]  page_copy [PAGE];
   logic [15:0] seg_first;
   logic [15:0] seg_next;
   logic        seg_open;
   logic        seg_dirty;

   // shadow of the window registers
   logic [16:0] cfg_lo, cfg_hi, meta_lo, meta_hi, boot_lo, write_hi;

   access_outcome_type awaited_outcomes [$];
   access_outcome_type got, want;

   function automatic logic [7:0] stored_byte(int unsigned a);
      return (a < STORE) ? store_mem[a] : 8'hFF;
   endfunction

   // true when [lo_b, hi_b] is a nonempty run lying inside [lo, hi)
   function automatic logic spans(logic [16:0] lo, logic [16:0] hi, logic [16:0] lo_b,
                                  logic [16:0] hi_b);
      return lo_b <= hi_b && lo <= lo_b && hi_b < hi;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // one read or one write byte: update the shadow state, return the outcome
   task automatic apply_access(input logic op, input logic [15:0] addr, input logic [7:0] data,
                               input logic last_byte, output access_outcome_type res);
      int unsigned base;
      int unsigned cur;
      logic        allowed;
      res = '0;
      if (op == OP_READ) begin
         if (spans(cfg_lo, cfg_hi, {1'b0, addr}, {1'b0, addr}) ||
             spans(meta_lo, meta_hi, {1'b0, addr}, {1'b0, addr})) begin
            res.read_data = stored_byte(addr);
            res.status    = STATUS_READ_OK;
         end else begin
            res.status = STATUS_READ_DENY;
         end
      end else begin
         // opening a segment loads its page from the store
         if (!seg_open) begin
            base      = addr - addr % PAGE;
            seg_first = addr;
            seg_next  = addr;
            seg_open  = 1'b1;
            seg_dirty = 1'b0;
            for (int i = 0; i < PAGE; i++)
               page_copy[i] = stored_byte(base + i);
         end
         cur = seg_next;
         if (page_copy[cur % PAGE] != data)
            seg_dirty = 1'b1;
         page_copy[cur % PAGE] = data;
         seg_next   = seg_next + 16'd1;
         res.status = STATUS_BUFFERED;
         // close at the request end, at a page boundary or on address wrap
         if (last_byte || seg_next == 16'd0 || seg_next % PAGE == 0) begin
            allowed = (spans(cfg_lo, cfg_hi, {1'b0, seg_first}, 17'(cur)) ||
                       spans(boot_lo, write_hi, {1'b0, seg_first}, 17'(cur))) && cur < STORE;
            seg_open = 1'b0;
            if (!allowed) begin
               res.status = STATUS_WRITE_DENY;
            end else begin
               base = seg_first - seg_first % PAGE;
               if (seg_dirty) begin
                  for (int i = 0; i < PAGE; i++)
                     if (base + i < STORE)
                        store_mem[base + i] = page_copy[i];
                  res.status = STATUS_PROGRAMMED;
                  pages_programmed++;
               end else begin
                  res.status = STATUS_UNCHANGED;
               end
               res.page_index = 9'(seg_first / PAGE);
            end
            seg_dirty = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE; i++)
            store_mem[i] = 8'hFF;
         seg_first = '0;
         seg_next  = '0;
         seg_open  = 1'b0;
         seg_dirty = 1'b0;
         cfg_lo    = '0;
         cfg_hi    = '0;
         meta_lo   = '0;
         meta_hi   = '0;
         boot_lo   = '0;
         write_hi  = 17'(STORE);
         awaited_outcomes.delete();
      end else begin
         // result transfer: compare against the oldest outstanding access
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch($sformatf("result status %0d arrived with nothing due",
                                         rsp_status));
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch($sformatf("read_data got %02h want %02h",
                                            rsp_read_data, want.read_data));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_page_index !== want.page_index)
                  report_mismatch($sformatf("page_index got %0d want %0d",
                                            rsp_page_index, want.page_index));
            end
         end
         // register transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CONFIG_START: cfg_lo   = {1'b0, csr_data[15:0]};
               REG_CONFIG_END:   cfg_hi   = csr_data;
               REG_META_START:   meta_lo  = {1'b0, csr_data[15:0]};
               REG_META_END:     meta_hi  = csr_data;
               REG_BOOT_START:   boot_lo  = {1'b0, csr_data[15:0]};
               REG_FLASH_LIMIT:  write_hi = csr_data;
               default: ;
            endcase
         end
         // request transfer
         if (start && !busy) begin
            apply_access(req_operation, req_address, req_data, req_last, got);
            awaited_outcomes.push_back(got);
         end
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import pfpw_pkg::*;

   // indexes past the last register, writes there must be dropped
   localparam logic [2:0] REG_UNUSED_A = 3'd6;
   localparam logic [2:0] REG_UNUSED_B = 3'd7;

   localparam int RANDOM_ITEMS  = 950;
   localparam int PHASE_ITEMS   = 120;
   localparam int SETTLE_CYCLES = 80;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int STORE         = DEF_FLASH_BYTES;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_READ;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_page_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   int mismatches, outstanding, pages_programmed;
   int items_sent, reads_sent, bytes_sent, settings_used, directed_items, phase_stop;
   logic quiet = 1'b0;

   // current window settings, used to aim addresses
   int cfg_lo = 0, cfg_hi = 0, meta_lo = 0, meta_hi = 0, boot_lo = 0, write_hi = STORE;

   // previous write request, replayed to hit the unchanged-page case
   logic [15:0] prev_first;
   logic [7:0]  prev_bytes [$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   protected_flash_page_writer_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .rsp_page_index (rsp_page_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   pfpw_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_page_index   (rsp_page_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .pages_programmed (pages_programmed)
   );

   // one request transfer; start stays high so back-to-back items need no gap
   task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] data,
                            input logic last_byte);
      while (!quiet && $urandom_range(99) < 7) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_address   <= addr;
      req_data      <= data;
      req_last      <= last_byte;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
      if (op == OP_READ)
         reads_sent++;
      else
         bytes_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // drop start, wait for every result, then let a page copy finish
   task automatic settle();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_windows(input int cs, input int ce, input int ms, input int me,
                              input int bs, input int fl);
      settle();
      write_reg(REG_CONFIG_START, 17'(cs));
      write_reg(REG_CONFIG_END, 17'(ce));
      write_reg(REG_META_START, 17'(ms));
      write_reg(REG_META_END, 17'(me));
      write_reg(REG_BOOT_START, 17'(bs));
      write_reg(REG_FLASH_LIMIT, 17'(fl));
      write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, 17'($urandom));
      csr_valid <= 1'b0;
      cfg_lo   = cs & 16'hFFFF;
      cfg_hi   = ce & 17'h1FFFF;
      meta_lo  = ms & 16'hFFFF;
      meta_hi  = me & 17'h1FFFF;
      boot_lo  = bs & 16'hFFFF;
      write_hi = fl & 17'h1FFFF;
      settings_used++;
   endtask

   // random address in [lo, hi), anywhere when that range is empty
   function automatic logic [15:0] pick_span(int lo, int hi);
      if (hi > 65536)
         hi = 65536;
      if (hi > lo)
         return 16'(lo + $urandom % (hi - lo));
      return 16'($urandom);
   endfunction

   function automatic int window_end(int lo);
      case ($urandom_range(3))
         0: return $urandom_range(lo);
         1, 2: return (lo + $urandom_range(1, 4096) > 65536) ? 65536
                      : lo + $urandom_range(1, 4096);
         default: return $urandom & 17'h1FFFF;
      endcase
   endfunction

   task automatic random_windows();
      int cs, ms, bs, fl;
      cs = $urandom_range(65535);
      ms = $urandom_range(65535);
      bs = ($urandom_range(99) < 70) ? $urandom_range(STORE - 1) : $urandom_range(65535);
      case ($urandom_range(19))
         0, 1, 2: fl = $urandom & 17'h1FFFF;
         3, 4, 5, 6, 7: fl = $urandom_range(65536, bs);
         default: fl = STORE;
      endcase
      set_windows(cs, window_end(cs), ms, window_end(ms), bs, fl);
   endtask

   function automatic logic [15:0] pick_write_addr();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return pick_span(boot_lo, (write_hi < STORE) ? write_hi : STORE);
      if (r < 65)
         return pick_span(cfg_lo, cfg_hi);
      if (r < 80)
         return 16'(($urandom & 32'hFFC0) + 32'd64 - 32'($urandom_range(1, 4)));
      if (r < 88)
         return 16'hFFFF - 16'($urandom_range(8));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_read_addr();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         return pick_span(cfg_lo, cfg_hi);
      if (r < 75)
         return pick_span(meta_lo, meta_hi);
      return 16'($urandom);
   endfunction

   // a lone read, or a write request with reads mixed in
   task automatic run_request();
      int          kind, len;
      logic        erased, broken;
      logic [15:0] first_addr;
      logic [7:0]  bytes [$];
      kind = $urandom_range(99);
      if (kind < 20) begin
         send_item(OP_READ, pick_read_addr(), 8'($urandom), 1'($urandom));
      end else begin
         if (kind < 32 && prev_bytes.size() != 0) begin
            first_addr = prev_first;
            bytes      = prev_bytes;
         end else begin
            first_addr = pick_write_addr();
            case ($urandom_range(19))
               0: len = $urandom_range(60, 130);
               1, 2, 3, 4: len = $urandom_range(7, 70);
               default: len = $urandom_range(1, 6);
            endcase
            erased = $urandom_range(99) < 25;
            for (int i = 0; i < len; i++)
               bytes.push_back(erased ? 8'hFF : 8'($urandom));
         end
         // broken requests carry junk addresses past the first byte
         broken = $urandom_range(99) < 10;
         for (int i = 0; i < bytes.size(); i++) begin
            if ($urandom_range(99) < 10)
               send_item(OP_READ, pick_read_addr(), 8'($urandom), 1'($urandom));
            send_item(OP_WRITE, (broken && i != 0) ? 16'($urandom) : first_addr + 16'(i),
                      bytes[i], i == bytes.size() - 1);
         end
         prev_first = first_addr;
         prev_bytes = bytes;
      end
   endtask

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset windows: reads refused, writes allowed below the flash size
      send_item(OP_READ, 16'h0000, 8'h00, 1'b0);
      send_item(OP_WRITE, 16'h0000, 8'h00, 1'b1);

      // config window at the top of the address space, meta at the bottom
      set_windows(16'hFFC0, 65536, 16'h0000, 16'h0080, 16'h0100, STORE);
      send_item(OP_READ, 16'h0000, 8'h00, 1'b0);
      send_item(OP_READ, 16'hFFFF, 8'h00, 1'b1);
      // request that wraps past the last address, refused on both sides
      send_item(OP_WRITE, 16'hFFFE, 8'hA5, 1'b0);
      send_item(OP_WRITE, 16'hFFFF, 8'hFF, 1'b0);
      send_item(OP_WRITE, 16'h0000, 8'h12, 1'b0);
      send_item(OP_WRITE, 16'h0001, 8'h34, 1'b1);
      // crossing into the boot area at a page boundary
      send_item(OP_WRITE, 16'h00FF, 8'h5A, 1'b0);
      send_item(OP_WRITE, 16'h0100, 8'hFF, 1'b0);
      send_item(OP_WRITE, 16'h0101, 8'h80, 1'b0);
      send_item(OP_WRITE, 16'h0102, 8'h01, 1'b1);
      // read in the middle of an open segment, then the same bytes again
      send_item(OP_WRITE, 16'h0140, 8'h11, 1'b0);
      send_item(OP_READ, 16'h0000, 8'h00, 1'b0);
      send_item(OP_WRITE, 16'h0141, 8'hFF, 1'b1);
      send_item(OP_WRITE, 16'h0140, 8'h11, 1'b0);
      send_item(OP_WRITE, 16'h0141, 8'hFF, 1'b1);
      // last page of the store, then just past it
      send_item(OP_WRITE, 16'h7FFF, 8'h00, 1'b1);
      send_item(OP_WRITE, 16'h8000, 8'h00, 1'b1);

      // widest windows: config covers everything, limit at its top value
      set_windows(16'h0000, 65536, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
      send_item(OP_READ, 16'h1234, 8'h00, 1'b0);
      send_item(OP_READ, 16'hFFFF, 8'h00, 1'b0);
      send_item(OP_WRITE, 16'hFFFF, 8'h77, 1'b1);
      send_item(OP_WRITE, 16'h0040, 8'h3C, 1'b1);

      // every window with its end below its start
      set_windows(16'h8000, 16'h0010, 16'hFFFF, 0, 16'h4000, 16'h2000);
      send_item(OP_READ, 16'h0008, 8'h00, 1'b0);
      send_item(OP_WRITE, 16'h0008, 8'h00, 1'b1);
      send_item(OP_WRITE, 16'h3000, 8'h00, 1'b1);
      directed_items = items_sent;

      // random phases, each with fresh windows; one runs with no gaps at all
      phase = 0;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         random_windows();
         quiet      = (phase == 2);
         phase_stop = items_sent + PHASE_ITEMS;
         while (items_sent < phase_stop)
            run_request();
         quiet = 1'b0;
         phase++;
      end

      settle();
      $display("sent %0d reads and %0d write bytes under %0d window settings",
               reads_sent, bytes_sent, settings_used);
      $display("%0d pages programmed, %0d results still owed", pages_programmed, outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
